FILE: sv/pcm_voice_mixer_unit_assert.svh
// Assertion macros for the voice mixer.
`ifndef PCM_VOICE_MIXER_UNIT_ASSERT_SVH
`define PCM_VOICE_MIXER_UNIT_ASSERT_SVH

// Same-cycle implication, checked on clk, off during rst.
`define PVM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pvm assertion failed");

// Next-cycle implication, checked on clk, off during rst.
`define PVM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pvm assertion failed");

`endif

FILE: sv/pvm_pkg.sv
// Shared types, constants and helpers of the voice mixer.
package pvm_pkg;

  localparam int VOICE_COUNT_DEF      = 16;
  localparam int SAMPLE_MEM_DEPTH_DEF = 65536;
  localparam int QUEUE_DEPTH          = 2;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_START = 2'd1,
    ACT_MIX   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    action_t     kind;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [3:0]  vidx;
    logic [15:0] base;
    logic [15:0] len;
    logic [15:0] lp;
    logic        loops;
    logic [7:0]  lvol;
    logic [7:0]  rvol;
  } cmd_t;

  typedef struct packed {
    logic [15:0] base;
    logic [15:0] len;
    logic [15:0] lp;
    logic        loops;
    logic [7:0]  lvol;
    logic [7:0]  rvol;
  } voice_stat_t;

  typedef struct packed {
    logic [15:0] pos;
    logic [15:0] rem;
  } voice_dyn_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VOICE,
    ST_ADDR,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } state_t;

  function automatic logic [7:0] sat255(logic [8:0] g);
    return g[8] ? 8'hFF : g[7:0];
  endfunction

  function automatic logic signed [15:0] clamp16(logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) r = 16'sh7FFF;
    else if (v < -18'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

FILE: sv/pvm_fifo.sv
// Short queue used for commands between front and back, and for results.
module pvm_fifo #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] data_in,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] data_out,
  output logic         empty
);

  localparam int DEPTH = pvm_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [W-1:0]     q [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == FULL_CNT);
  assign empty    = (count == '0);
  assign data_out = q[rptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == LAST) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == LAST) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: sv/pvm_back.sv
// Back end: sample memory, voice table and the per-frame mixing sequencer.
module pvm_back #(
  parameter int VOICE_COUNT      = pvm_pkg::VOICE_COUNT_DEF,
  parameter int SAMPLE_MEM_DEPTH = pvm_pkg::SAMPLE_MEM_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  pvm_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output logic [31:0]   res_data
);

  `include "pcm_voice_mixer_unit_assert.svh"

  localparam int ADDR_W = $clog2(SAMPLE_MEM_DEPTH);
  localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam logic [VIDX_W-1:0] LAST = VIDX_W'(VOICE_COUNT - 1);

  pvm_pkg::state_t      state;
  pvm_pkg::state_t      state_next;
  logic [VIDX_W-1:0]    vidx;
  logic [VOICE_COUNT-1:0] active;

  logic [7:0]           sample_mem [SAMPLE_MEM_DEPTH];
  pvm_pkg::voice_stat_t stat_mem [VOICE_COUNT];
  pvm_pkg::voice_dyn_t  dyn_mem [VOICE_COUNT];
  pvm_pkg::voice_stat_t stat_q;
  pvm_pkg::voice_dyn_t  dyn_q;
  logic [7:0]           smp_q;

  logic [15:0]          cur_pos;
  logic [15:0]          cur_rem;
  logic signed [16:0]   prod_l;
  logic signed [16:0]   prod_r;
  logic signed [15:0]   sum_l;
  logic signed [15:0]   sum_r;

  logic                 play;
  logic                 at_end;
  logic                 can_loop;
  logic                 go;
  logic [15:0]          pos_eff;
  logic [15:0]          rem_eff;
  logic [15:0]          loop_len;
  logic [ADDR_W-1:0]    rd_addr;
  logic [15:0]          rem_dec;
  logic [15:0]          pos_inc;
  logic signed [7:0]    smp_s;
  logic                 take;
  logic                 start_ok;
  logic [VIDX_W-1:0]    widx;
  pvm_pkg::voice_dyn_t  dyn_wb;

  assign play     = active[vidx] && (stat_q.lvol != 8'd0 || stat_q.rvol != 8'd0);
  assign at_end   = (dyn_q.rem == 16'd0);
  assign can_loop = stat_q.loops && (stat_q.len > stat_q.lp);
  assign go       = play && (!at_end || can_loop);
  assign loop_len = stat_q.len - stat_q.lp;
  assign pos_eff  = at_end ? stat_q.lp : dyn_q.pos;
  assign rem_eff  = at_end ? loop_len : dyn_q.rem;
  assign rd_addr  = ADDR_W'({1'b0, stat_q.base} + {1'b0, pos_eff});
  assign rem_dec  = cur_rem - 16'd1;
  assign pos_inc  = cur_pos + 16'd1;
  assign smp_s    = {~smp_q[7], smp_q[6:0]};
  assign take     = (state == pvm_pkg::ST_IDLE) && !cmd_empty;
  assign start_ok = ({4'b0, cmd.vidx} < 8'(VOICE_COUNT));
  assign widx     = VIDX_W'(cmd.vidx);
  assign res_data = {sum_l, sum_r};

  always_comb begin
    if (rem_dec == 16'd0 && can_loop) begin
      dyn_wb.pos = stat_q.lp;
      dyn_wb.rem = loop_len;
    end else begin
      dyn_wb.pos = pos_inc;
      dyn_wb.rem = rem_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pvm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    res_push   = 1'b0;
    unique case (state)
      pvm_pkg::ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd.kind == pvm_pkg::ACT_MIX) state_next = pvm_pkg::ST_VOICE;
        end
      end
      pvm_pkg::ST_VOICE: state_next = pvm_pkg::ST_ADDR;
      pvm_pkg::ST_ADDR: begin
        if (go) state_next = pvm_pkg::ST_MUL;
        else if (vidx == LAST) state_next = pvm_pkg::ST_DONE;
        else state_next = pvm_pkg::ST_VOICE;
      end
      pvm_pkg::ST_MUL: state_next = pvm_pkg::ST_ACC;
      pvm_pkg::ST_ACC: begin
        state_next = (vidx == LAST) ? pvm_pkg::ST_DONE : pvm_pkg::ST_VOICE;
      end
      pvm_pkg::ST_DONE: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = pvm_pkg::ST_IDLE;
        end
      end
      default: state_next = pvm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take && cmd.kind == pvm_pkg::ACT_WRITE) begin
      sample_mem[ADDR_W'(cmd.addr)] <= cmd.data;
    end
    smp_q <= sample_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (take && cmd.kind == pvm_pkg::ACT_START && start_ok) begin
      stat_mem[widx] <= '{base: cmd.base, len: cmd.len, lp: cmd.lp, loops: cmd.loops,
                          lvol: cmd.lvol, rvol: cmd.rvol};
    end
    stat_q <= stat_mem[vidx];
  end

  always_ff @(posedge clk) begin
    if (take && cmd.kind == pvm_pkg::ACT_START && start_ok) begin
      dyn_mem[widx] <= '{pos: 16'd0, rem: cmd.len};
    end else if (state == pvm_pkg::ST_ACC) begin
      dyn_mem[vidx] <= dyn_wb;
    end
    dyn_q <= dyn_mem[vidx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (take && cmd.kind == pvm_pkg::ACT_START && start_ok) begin
      active[widx] <= 1'b1;
    end else if (state == pvm_pkg::ST_ADDR && play && at_end && !can_loop) begin
      active[vidx] <= 1'b0;
    end else if (state == pvm_pkg::ST_ACC && rem_dec == 16'd0 && !can_loop) begin
      active[vidx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      pvm_pkg::ST_IDLE: begin
        if (take && cmd.kind == pvm_pkg::ACT_MIX) begin
          vidx  <= '0;
          sum_l <= '0;
          sum_r <= '0;
        end
      end
      pvm_pkg::ST_ADDR: begin
        cur_pos <= pos_eff;
        cur_rem <= rem_eff;
        if (!go && vidx != LAST) vidx <= vidx + 1'b1;
      end
      pvm_pkg::ST_MUL: begin
        prod_l <= smp_s * $signed({1'b0, stat_q.lvol});
        prod_r <= smp_s * $signed({1'b0, stat_q.rvol});
      end
      pvm_pkg::ST_ACC: begin
        sum_l <= pvm_pkg::clamp16(18'(sum_l) + 18'(prod_l));
        sum_r <= pvm_pkg::clamp16(18'(sum_r) + 18'(prod_r));
        if (vidx != LAST) vidx <= vidx + 1'b1;
      end
      default: begin
      end
    endcase
  end

  `PVM_ASSERT_NEXT(a_mix_start, take && cmd.kind == pvm_pkg::ACT_MIX,
                   state == pvm_pkg::ST_VOICE && vidx == '0 && sum_l == '0 && sum_r == '0)
  `PVM_ASSERT_IMPL(a_play_active, state == pvm_pkg::ST_MUL, active[vidx])
  `PVM_ASSERT_IMPL(a_play_rem, state == pvm_pkg::ST_MUL, cur_rem != 16'd0)

endmodule

FILE: sv/pcm_voice_mixer_unit.sv
// Top level of the multi-voice PCM mixer: front classifier, queues and back end.
// Items enter through a two-deep command queue; the unused action code is
// dropped on entry and gains are saturated to 255 there. The back end takes
// one command at a time: a sample write or a voice start is carried out in the
// cycle in which it is taken from the queue. A mix frame walks every voice in
// turn: each voice costs one voice-table read and one sample-memory read, and
// a voice that plays a sample in that frame adds a multiply and an accumulate
// step. Results wait in a two-deep result queue, so the back end continues
// while the consumer stalls until that queue fills. The sample memory is not
// cleared; read only bytes that have been written. Its depth must be a power
// of two, and addresses wrap modulo that depth.
module pcm_voice_mixer_unit #(
  parameter int VOICE_COUNT      = pvm_pkg::VOICE_COUNT_DEF,
  parameter int SAMPLE_MEM_DEPTH = pvm_pkg::SAMPLE_MEM_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         action,
  input  logic [15:0]        sample_addr,
  input  logic [7:0]         sample_byte,
  input  logic [3:0]         voice_index,
  input  logic [15:0]        voice_base,
  input  logic [15:0]        voice_length,
  input  logic [15:0]        loop_start,
  input  logic               loop_enable,
  input  logic [8:0]         left_gain,
  input  logic [8:0]         right_gain,
  output logic               empty,
  input  logic               pop,
  output logic signed [15:0] left_out,
  output logic signed [15:0] right_out
);

  localparam int CMD_W = $bits(pvm_pkg::cmd_t);

  pvm_pkg::cmd_t cmd_in;
  pvm_pkg::cmd_t cmd_out;
  logic [CMD_W-1:0] cmd_bits;
  logic          cmd_push;
  logic          cmd_empty;
  logic          cmd_pop;
  logic          res_push;
  logic          res_full;
  logic [31:0]   res_data;
  logic [31:0]   res_out;

  always_comb begin
    cmd_in.kind  = pvm_pkg::action_t'(action);
    cmd_in.addr  = sample_addr;
    cmd_in.data  = sample_byte;
    cmd_in.vidx  = voice_index;
    cmd_in.base  = voice_base;
    cmd_in.len   = voice_length;
    cmd_in.lp    = loop_start;
    cmd_in.loops = loop_enable;
    cmd_in.lvol  = pvm_pkg::sat255(left_gain);
    cmd_in.rvol  = pvm_pkg::sat255(right_gain);
  end

  assign cmd_push = push && (cmd_in.kind != pvm_pkg::ACT_NONE);
  assign cmd_out  = pvm_pkg::cmd_t'(cmd_bits);

  pvm_fifo #(.W(CMD_W)) u_cmd_q (
    .clk      (clk),
    .rst      (rst),
    .push     (cmd_push),
    .data_in  (CMD_W'(cmd_in)),
    .full     (full),
    .pop      (cmd_pop),
    .data_out (cmd_bits),
    .empty    (cmd_empty)
  );

  pvm_back #(
    .VOICE_COUNT      (VOICE_COUNT),
    .SAMPLE_MEM_DEPTH (SAMPLE_MEM_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  pvm_fifo #(.W(32)) u_res_q (
    .clk      (clk),
    .rst      (rst),
    .push     (res_push),
    .data_in  (res_data),
    .full     (res_full),
    .pop      (pop),
    .data_out (res_out),
    .empty    (empty)
  );

  assign left_out  = $signed(res_out[31:16]);
  assign right_out = $signed(res_out[15:0]);

endmodule
